>>> rtl/core/sdp_pkg.sv
package sdp_pkg;

  // Item operation codes.
  typedef enum logic [2:0] {
    FN_START     = 3'd0,
    FN_START_END = 3'd1,
    FN_RESERVE   = 3'd2,
    FN_DATA      = 3'd3,
    FN_READ      = 3'd4
  } func_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_COUNT_FULL = 3'd1,
    ST_NO_ROOM    = 3'd2,
    ST_STRAY      = 3'd3,
    ST_OFFSET     = 3'd4,
    ST_UNFINISHED = 3'd5
  } status_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SESSION_HIGH = 1'd0,
    CFG_SESSION_LOW  = 1'd1
  } cfg_index_t;

  localparam int unsigned HDR_LEN    = 20;
  localparam int unsigned LEN_PREFIX = 2;
  // Width of size arithmetic; covers the largest allowed packet plus a message.
  localparam int unsigned CALC_W     = 18;

  localparam logic [15:0] COUNT_END      = 16'hFFFF;
  localparam logic [15:0] COUNT_LAST     = 16'hFFFE;
  localparam logic [15:0] SESSION_HI_RST = 16'h2020;
  localparam logic [63:0] SESSION_LO_RST = 64'h2020_2020_2020_2020;

  // Result of one item as it leaves the control stage.
  typedef struct packed {
    status_t     status;
    logic [7:0]  hdr_byte;
    logic        from_mem;
    logic        odd_lane;
    logic [11:0] size;
    logic [15:0] count;
  } sdp_result_t;

  // Header byte at a position below the header length, zero elsewhere.
  function automatic logic [7:0] header_byte(input logic [10:0] off,
                                             input logic [15:0] sess_hi,
                                             input logic [63:0] sess_lo,
                                             input logic [63:0] seq,
                                             input logic [15:0] count);
    logic [159:0] hdr;
    logic [4:0]   idx;
    hdr = {sess_hi, sess_lo, seq, count};
    idx = 5'(HDR_LEN - 1) - off[4:0];
    if (off >= 11'(HDR_LEN)) begin
      return 8'h00;
    end
    return hdr[{idx, 3'b000} +: 8];
  endfunction

endpackage

>>> rtl/core/sdp_if.sv
interface sdp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [63:0] seq_num;
  logic [15:0] message_length;
  logic [7:0]  data_byte;
  logic [10:0] read_offset;

  modport source (output valid, func, seq_num, message_length, data_byte,
                  read_offset, input ready);
  modport sink (input valid, func, seq_num, message_length, data_byte,
                read_offset, output ready);
endinterface

interface sdp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  read_byte;
  logic [11:0] packet_size;
  logic [15:0] msg_count;

  modport source (output valid, status, read_byte, packet_size, msg_count,
                  input ready);
  modport sink (input valid, status, read_byte, packet_size, msg_count,
                output ready);
endinterface

>>> rtl/core/sdp_lane_ram.sv
module sdp_lane_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/sdp_ctrl.sv
module sdp_ctrl #(
  parameter int unsigned PACKET_BYTES = 2048,
  parameter int unsigned AW           = $clog2((PACKET_BYTES + 1) / 2)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [2:0]               func,
  input  logic [63:0]              seq_num,
  input  logic [15:0]              message_length,
  input  logic [7:0]               data_byte,
  input  logic [10:0]              read_offset,
  input  logic                     cfg_we,
  input  sdp_pkg::cfg_index_t      cfg_index,
  input  logic [63:0]              cfg_data,
  output sdp_pkg::sdp_result_t     result,
  output logic                     wr_en0,
  output logic [AW-1:0]            wr_addr0,
  output logic [7:0]               wr_data0,
  output logic                     wr_en1,
  output logic [AW-1:0]            wr_addr1,
  output logic [7:0]               wr_data1,
  output logic [AW-1:0]            rd_addr
);

  import sdp_pkg::*;

  localparam int unsigned UW = $clog2(PACKET_BYTES + 1);

  // Packet state. The fill position always equals the used length once a
  // message is open, so a single register serves both.
  logic [UW-1:0] used_r, used_nxt;
  logic [15:0]   count_r, count_nxt;
  logic [15:0]   expect_r, expect_nxt;
  logic [63:0]   seq_r, seq_nxt;
  logic [15:0]   sess_hi_r;
  logic [63:0]   sess_lo_r;

  logic [UW-1:0]     used_p1;
  logic [CALC_W-1:0] room_need;
  logic              off_beyond;

  assign used_p1    = used_r + UW'(1);
  assign room_need  = CALC_W'(used_r) + CALC_W'(LEN_PREFIX) + CALC_W'(message_length);
  assign off_beyond = CALC_W'(read_offset) >= CALC_W'(used_r);
  assign rd_addr    = AW'(read_offset[10:1]);

  // Decode of one item: next state, result and buffer writes.
  always_comb begin
    used_nxt   = used_r;
    count_nxt  = count_r;
    expect_nxt = expect_r;
    seq_nxt    = seq_r;
    result     = '0;
    result.status = ST_OK;
    wr_en0   = 1'b0;
    wr_en1   = 1'b0;
    wr_addr0 = AW'(used_r >> 1);
    wr_addr1 = AW'(used_r >> 1);
    wr_data0 = data_byte;
    wr_data1 = data_byte;
    unique case (func_t'(func)) inside
      FN_START, FN_START_END: begin
        seq_nxt    = seq_num;
        count_nxt  = (func_t'(func) == FN_START_END) ? COUNT_END : 16'd0;
        used_nxt   = UW'(HDR_LEN);
        expect_nxt = 16'd0;
      end
      FN_RESERVE: begin
        if (expect_r != 16'd0) begin
          result.status = ST_UNFINISHED;
        end else if (count_r == COUNT_END || count_r == COUNT_LAST) begin
          result.status = ST_COUNT_FULL;
        end else if (room_need > CALC_W'(PACKET_BYTES)) begin
          result.status = ST_NO_ROOM;
        end else begin
          // Length prefix goes out big-endian over both lanes.
          wr_en0 = accept;
          wr_en1 = accept;
          if (used_r[0]) begin
            wr_data1 = message_length[15:8];
            wr_data0 = message_length[7:0];
            wr_addr0 = AW'(used_p1 >> 1);
          end else begin
            wr_data0 = message_length[15:8];
            wr_data1 = message_length[7:0];
          end
          used_nxt   = used_r + UW'(LEN_PREFIX);
          expect_nxt = message_length;
          count_nxt  = count_r + 16'd1;
        end
      end
      FN_DATA: begin
        if (expect_r == 16'd0) begin
          result.status = ST_STRAY;
        end else begin
          wr_en0     = accept & ~used_r[0];
          wr_en1     = accept & used_r[0];
          used_nxt   = used_p1;
          expect_nxt = expect_r - 16'd1;
        end
      end
      FN_READ: begin
        if (off_beyond) begin
          result.status = ST_OFFSET;
        end else if (read_offset < 11'(HDR_LEN)) begin
          result.hdr_byte = header_byte(read_offset, sess_hi_r, sess_lo_r, seq_r,
                                        count_r);
        end else begin
          result.from_mem = 1'b1;
          result.odd_lane = read_offset[0];
        end
      end
      default: begin
      end
    endcase
    result.size  = 12'(used_nxt);
    result.count = count_nxt;
  end

  // State update on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= UW'(HDR_LEN);
      count_r  <= 16'd0;
      expect_r <= 16'd0;
      seq_r    <= 64'd0;
    end else if (accept) begin
      used_r   <= used_nxt;
      count_r  <= count_nxt;
      expect_r <= expect_nxt;
      seq_r    <= seq_nxt;
    end
  end

  // Session registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_hi_r <= SESSION_HI_RST;
      sess_lo_r <= SESSION_LO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SESSION_HIGH: sess_hi_r <= cfg_data[15:0];
        CFG_SESSION_LOW:  sess_lo_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/sequenced_datagram_packer.sv
// Packet builder for sequenced datagrams: a 20-byte header (session,
// sequence number, message count) followed by length-prefixed messages.
// Input words arrive on in_bus: start packet, start end-of-session packet,
// reserve message, data byte or read byte. Every input word yields exactly
// one result word on out_bus with a status, the byte read, the packet size
// and the message count after the word took effect.
// The session string is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while the block is idle; the block does not enforce this.
// A result is valid in the cycle after acceptance; one word is taken per
// cycle unless stalled; the payload buffer is split into even and odd
// byte lanes, each a single-port-write memory, so both prefix bytes are
// written at once. Header bytes come from registers at read time. The
// result register holds its word while out_bus.ready is low, and a new
// input word is taken in the same cycle the held result is taken.
// Synchronous reset starts an empty packet with sequence zero, count zero
// and a blank session; the buffer needs no clearing since only bytes
// written in the current packet are ever read.
module sequenced_datagram_packer #(
  parameter int unsigned PACKET_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  sdp_in_if.sink              in_bus,
  sdp_out_if.source           out_bus,
  input  logic                cfg_we,
  input  sdp_pkg::cfg_index_t cfg_index,
  input  logic [63:0]         cfg_data
);

  import sdp_pkg::*;

  localparam int unsigned DEPTH = (PACKET_BYTES + 1) / 2;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic          accept;
  logic          valid_r;
  sdp_result_t   res_now;
  sdp_result_t   res_r;
  logic          wr_en0, wr_en1;
  logic [AW-1:0] wr_addr0, wr_addr1, rd_addr;
  logic [7:0]    wr_data0, wr_data1, rd_data0, rd_data1;

  assign in_bus.ready = ~valid_r | out_bus.ready;
  assign accept       = in_bus.valid & in_bus.ready;

  sdp_ctrl #(
    .PACKET_BYTES (PACKET_BYTES),
    .AW           (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .func            (in_bus.func),
    .seq_num         (in_bus.seq_num),
    .message_length  (in_bus.message_length),
    .data_byte       (in_bus.data_byte),
    .read_offset     (in_bus.read_offset),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .result          (res_now),
    .wr_en0          (wr_en0),
    .wr_addr0        (wr_addr0),
    .wr_data0        (wr_data0),
    .wr_en1          (wr_en1),
    .wr_addr1        (wr_addr1),
    .wr_data1        (wr_data1),
    .rd_addr         (rd_addr)
  );

  // Even byte positions.
  sdp_lane_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_lane0 (
    .clk     (clk),
    .wr_en   (wr_en0),
    .wr_addr (wr_addr0),
    .wr_data (wr_data0),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data0)
  );

  // Odd byte positions.
  sdp_lane_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_lane1 (
    .clk     (clk),
    .wr_en   (wr_en1),
    .wr_addr (wr_addr1),
    .wr_data (wr_data1),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data1)
  );

  // Result register; the lane read data is captured alongside it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_now;
    end
  end

  // Result word.
  assign out_bus.valid       = valid_r;
  assign out_bus.status      = res_r.status;
  assign out_bus.packet_size = res_r.size;
  assign out_bus.msg_count   = res_r.count;
  assign out_bus.read_byte   = !res_r.from_mem ? res_r.hdr_byte :
                               (res_r.odd_lane ? rd_data1 : rd_data0);

  // Every accepted word produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_bus.valid)
    else $error("accepted word produced no result");

  // A read beyond the packet returns zero.
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.status == ST_OFFSET) |-> out_bus.read_byte == 8'h00)
    else $error("out-of-range read returned data");

  // A full-count refusal only happens at the top two count values.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.status == ST_COUNT_FULL) |->
      (out_bus.msg_count == COUNT_END || out_bus.msg_count == COUNT_LAST))
    else $error("count-full status with room in the count");

  // Two lanes are written together only for a length prefix.
  a_pair_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en0 && wr_en1) |-> (accept && in_bus.func == FN_RESERVE))
    else $error("both lanes written outside a reservation");

endmodule

>>> tb/sv/sequenced_datagram_packer_test.sv
`timescale 1ns / 100ps

module sequenced_datagram_packer_test;
  import sdp_pkg::*;

  localparam int BUF_BYTES       = 2048;
  localparam int RANDOM_WORDS    = 650;
  localparam int LONG_HOLD       = 200;
  localparam int WATCHDOG_CYCLES = 2000;

  // Function codes the block treats as no operation.
  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] seq;
    logic [15:0] len;
    logic [7:0]  data;
    logic [10:0] off;
  } packer_word_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  rbyte;
    logic [11:0] size;
    logic [15:0] count;
  } packer_reply_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_index_t  cfg_index;
  logic [63:0] cfg_data;

  sdp_in_if  in_bus ();
  sdp_out_if out_bus ();

  sequenced_datagram_packer #(
    .PACKET_BYTES(BUF_BYTES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the packet under construction.
  logic [7:0]  pkt_store [0:BUF_BYTES-1];
  logic [15:0] sess_hi;
  logic [63:0] sess_lo;
  logic [63:0] pkt_seq;
  logic [15:0] pkt_count;
  int          pkt_used;
  int          bytes_owed;
  int          fill_at;

  packer_reply_t replies_due[$];

  int  src_gap_max;
  int  sink_stall_max;
  bit  hold_request;
  int  words_sent;
  int  replies_seen;
  int  fails;
  int  held_back;
  int  settings_written;
  int  packets_started;
  int  idle_run;
  int  status_tally [0:7];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reply the block owes for one accepted word; updates the shadow packet.
  function automatic packer_reply_t packet_reply(packer_word_t w);
    packer_reply_t r;
    logic [159:0]  hdr;
    int            pos;
    r = '0;
    r.status = ST_OK;
    case (w.func) inside
      FN_START, FN_START_END: begin
        pkt_seq    = w.seq;
        pkt_count  = (w.func == FN_START_END) ? COUNT_END : 16'h0000;
        pkt_used   = HDR_LEN;
        bytes_owed = 0;
        fill_at    = HDR_LEN;
      end
      FN_RESERVE: begin
        if (bytes_owed != 0) begin
          r.status = ST_UNFINISHED;
        end else if (pkt_count == COUNT_END || pkt_count == COUNT_LAST) begin
          r.status = ST_COUNT_FULL;
        end else if (pkt_used + int'(LEN_PREFIX) + int'(w.len) > BUF_BYTES) begin
          r.status = ST_NO_ROOM;
        end else begin
          pkt_store[pkt_used]     = w.len[15:8];
          pkt_store[pkt_used + 1] = w.len[7:0];
          pkt_used   = pkt_used + LEN_PREFIX;
          fill_at    = pkt_used;
          bytes_owed = w.len;
          pkt_count  = pkt_count + 16'd1;
        end
      end
      FN_DATA: begin
        if (bytes_owed == 0) begin
          r.status = ST_STRAY;
        end else begin
          pkt_store[fill_at] = w.data;
          fill_at++;
          pkt_used++;
          bytes_owed--;
        end
      end
      FN_READ: begin
        if (int'(w.off) >= pkt_used) begin
          r.status = ST_OFFSET;
        end else if (int'(w.off) < int'(HDR_LEN)) begin
          // Header bytes in wire order: session, sequence, count.
          hdr = {sess_hi, sess_lo, pkt_seq, pkt_count};
          pos = int'(HDR_LEN) - 1 - int'(w.off);
          r.rbyte = hdr[8*pos +: 8];
        end else begin
          r.rbyte = pkt_store[w.off];
        end
      end
      default: begin
      end
    endcase
    r.size  = pkt_used[11:0];
    r.count = pkt_count;
    return r;
  endfunction

  function automatic packer_word_t random_word(logic [2:0] f);
    packer_word_t w;
    w.func = f;
    w.seq  = {$urandom, $urandom};
    w.len  = 16'($urandom);
    w.data = 8'($urandom);
    w.off  = 11'($urandom);
    return w;
  endfunction

  function automatic int pick_pace();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 2;
      default: return 18;
    endcase
  endfunction

  // Offer one word after a random gap and record its reply once accepted.
  task automatic send_word(input packer_word_t w);
    int            gap;
    packer_reply_t r;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.func           <= w.func;
    in_bus.seq_num        <= w.seq;
    in_bus.message_length <= w.len;
    in_bus.data_byte      <= w.data;
    in_bus.read_offset    <= w.off;
    @(posedge clk);
    while (!in_bus.ready) begin
      held_back++;
      @(posedge clk);
    end
    r = packet_reply(w);
    replies_due.push_back(r);
    status_tally[r.status]++;
    words_sent++;
  endtask

  task automatic do_start(input bit eos_pkt, input logic [63:0] seq);
    packer_word_t w;
    w = random_word(eos_pkt ? FN_START_END : FN_START);
    w.seq = seq;
    send_word(w);
    packets_started++;
  endtask

  task automatic do_reserve(input logic [15:0] len);
    packer_word_t w;
    w = random_word(FN_RESERVE);
    w.len = len;
    send_word(w);
  endtask

  task automatic do_data(input logic [7:0] b);
    packer_word_t w;
    w = random_word(FN_DATA);
    w.data = b;
    send_word(w);
  endtask

  task automatic do_read(input logic [10:0] off);
    packer_word_t w;
    w = random_word(FN_READ);
    w.off = off;
    send_word(w);
  endtask

  // A word that does not belong in the current sequence.
  task automatic noise_word();
    case ($urandom_range(0, 2))
      0: send_word(random_word(FN_RESERVE));
      1: send_word(random_word(FN_READ));
      default: send_word(random_word(3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI))));
    endcase
  endtask

  // Stop offering words and wait until every reply has come back.
  task automatic wait_all_replies();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_SESSION_HIGH: sess_hi = val[15:0];
      CFG_SESSION_LOW:  sess_lo = val;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Upper bits of the high register write are junk; only 16 bits are kept.
  task automatic set_session(input logic [15:0] hi, input logic [63:0] lo);
    write_reg(CFG_SESSION_HIGH, {16'($urandom), 32'($urandom), hi});
    write_reg(CFG_SESSION_LOW, lo);
    settings_written++;
  endtask

  // Header reads with the reset session, reads past the end, a stray data byte and no-op words.
  task automatic test_header_after_reset();
    do_read(11'd0);
    do_read(11'(HDR_LEN));
    do_read(11'h7FF);
    do_data(8'hA5);
    send_word(random_word(FN_SPARE_LO));
    send_word(random_word(FN_SPARE_HI));
    wait_all_replies();
  endtask

  // Reservation rules: room, unfinished message, zero length, count full, stray data.
  task automatic test_message_rules();
    do_start(1'b0, '1);
    do_reserve(16'hFFFF);
    do_reserve(16'd3);
    do_reserve(16'd1);
    do_data(8'h00);
    do_data(8'hFF);
    do_read(11'd21);
    do_data(8'h5A);
    do_reserve(16'd0);
    do_reserve(16'd0);
    do_read(11'd22);
    do_data(8'h11);
    do_read(11'(HDR_LEN - 1));
    do_start(1'b1, '0);
    do_reserve(16'd1);
    do_read(11'(HDR_LEN - 2));
    do_read(11'(HDR_LEN - 1));
    wait_all_replies();
  endtask

  // Session registers at both extremes and one random setting.
  task automatic test_session_registers();
    set_session(16'h0000, 64'h0);
    do_read(11'd0);
    do_read(11'd1);
    do_read(11'd9);
    wait_all_replies();
    set_session(16'hFFFF, '1);
    do_read(11'd1);
    do_read(11'd2);
    do_read(11'd8);
    wait_all_replies();
    set_session(16'($urandom), {$urandom, $urandom});
    do_read(11'd0);
    do_read(11'd5);
    do_read(11'd9);
    wait_all_replies();
  endtask

  // Fill one packet to the last byte, mostly with empty messages.
  task automatic test_full_packet();
    int room;
    int len;
    src_gap_max    = pick_pace();
    sink_stall_max = pick_pace();
    do_start(1'b0, {$urandom, $urandom});
    do_reserve(16'(BUF_BYTES - HDR_LEN - LEN_PREFIX + 1));
    while (pkt_used + int'(LEN_PREFIX) <= BUF_BYTES) begin
      room = BUF_BYTES - pkt_used - LEN_PREFIX;
      if (room <= 5) begin
        len = room;
      end else if ($urandom_range(0, 99) < 75) begin
        len = 0;
      end else begin
        len = $urandom_range(1, 3);
      end
      do_reserve(16'(len));
      repeat (bytes_owed) do_data(8'($urandom));
      if ($urandom_range(0, 99) < 5) do_read(11'($urandom_range(0, pkt_used - 1)));
    end
    do_reserve(16'd0);
    do_read(11'(BUF_BYTES - 1));
    do_read(11'(HDR_LEN - 2));
    wait_all_replies();
  endtask

  // Receiver stops for a long stretch while words keep coming.
  task automatic test_backpressure();
    src_gap_max    = 0;
    sink_stall_max = 0;
    hold_request   = 1'b1;
    do_start(1'b0, {$urandom, $urandom});
    do_reserve(16'd40);
    repeat (40) do_data(8'($urandom));
    do_read(11'd30);
    // Sender holds back here until every reply is in.
    wait_all_replies();
  endtask

  task automatic random_packet(input int stop_at);
    int m;
    int n_msgs;
    int len;
    int n_bytes;
    int roll;
    do_start($urandom_range(0, 9) == 0, {$urandom, $urandom});
    n_msgs = $urandom_range(0, 10);
    for (m = 0; m < n_msgs && words_sent < stop_at; m++) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        len = $urandom_range(0, 6);
      end else if (roll < 85) begin
        len = $urandom_range(7, 40);
      end else if (roll < 95) begin
        len = $urandom_range(41, 255);
      end else begin
        len = $urandom_range(0, 65535);
      end
      do_reserve(16'(len));
      // Now and then leave a message short so the next one runs into it.
      n_bytes = bytes_owed;
      if ($urandom_range(0, 99) < 4) n_bytes = $urandom_range(0, n_bytes);
      repeat (n_bytes) begin
        if ($urandom_range(0, 99) < 4) noise_word();
        do_data(8'($urandom));
      end
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        do_read(11'($urandom_range(0, pkt_used - 1)));
      end else if (roll < 30) begin
        do_read(11'($urandom));
      end else if (roll < 35) begin
        do_data(8'($urandom));
      end else if (roll < 45) begin
        do_read(11'($urandom_range(0, HDR_LEN - 1)));
      end
    end
  endtask

  task automatic test_random_packets();
    int first;
    int pkt;
    first = words_sent;
    pkt = 0;
    while (words_sent - first < RANDOM_WORDS) begin
      if (pkt % 4 == 3) begin
        wait_all_replies();
        case ($urandom_range(0, 3))
          0: set_session(16'h0000, 64'h0);
          1: set_session(16'hFFFF, '1);
          default: set_session(16'($urandom), {$urandom, $urandom});
        endcase
      end
      src_gap_max    = pick_pace();
      sink_stall_max = pick_pace();
      random_packet(first + RANDOM_WORDS);
      pkt++;
    end
    wait_all_replies();
  endtask

  // Result side: random stalls per word, plus one long hold on request.
  initial begin : reply_sink
    int n;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        n = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        n = $urandom_range(0, sink_stall_max);
      end
      if (n > 0) begin
        out_bus.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
    end
  end

  // Compare each reply word with the oldest one owed.
  always @(posedge clk) begin : reply_check
    packer_reply_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        $error("Reply word arrived with none outstanding");
        fails++;
      end else begin
        want = replies_due.pop_front();
        if (out_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_bus.status);
          fails++;
        end
        if (out_bus.read_byte !== want.rbyte) begin
          $error("read_byte: expected %0h, got %0h", want.rbyte, out_bus.read_byte);
          fails++;
        end
        if (out_bus.packet_size !== want.size) begin
          $error("packet_size: expected %0d, got %0d", want.size, out_bus.packet_size);
          fails++;
        end
        if (out_bus.msg_count !== want.count) begin
          $error("msg_count: expected %0d, got %0d", want.count, out_bus.msg_count);
          fails++;
        end
      end
    end
  end

  // End the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= WATCHDOG_CYCLES) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_CYCLES);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_SESSION_HIGH;
    cfg_data              = '0;
    in_bus.valid          = 1'b0;
    in_bus.func           = FN_START;
    in_bus.seq_num        = '0;
    in_bus.message_length = '0;
    in_bus.data_byte      = '0;
    in_bus.read_offset    = '0;
    hold_request          = 1'b0;
    src_gap_max           = 3;
    sink_stall_max        = 3;
    foreach (status_tally[i]) status_tally[i] = 0;

    // Shadow state matches the block after reset.
    sess_hi    = SESSION_HI_RST;
    sess_lo    = SESSION_LO_RST;
    pkt_seq    = '0;
    pkt_count  = '0;
    pkt_used   = HDR_LEN;
    bytes_owed = 0;
    fill_at    = 0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_header_after_reset();
    test_message_rules();
    test_session_registers();
    test_full_packet();
    test_backpressure();
    test_random_packets();

    wait_all_replies();
    repeat (8) @(posedge clk);

    $display("Run covered %0d words, %0d replies, %0d packets, %0d session settings, %0d held cycles.",
             words_sent, replies_seen, packets_started, settings_written, held_back);
    $display("Statuses: ok %0d, count full %0d, no room %0d, stray %0d, offset %0d, unfinished %0d.",
             status_tally[ST_OK], status_tally[ST_COUNT_FULL], status_tally[ST_NO_ROOM],
             status_tally[ST_STRAY], status_tally[ST_OFFSET], status_tally[ST_UNFINISHED]);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sdp_pkg.sv
rtl/core/sdp_if.sv
rtl/core/sdp_lane_ram.sv
rtl/core/sdp_ctrl.sv
rtl/core/sequenced_datagram_packer.sv
tb/sv/sequenced_datagram_packer_test.sv
